[hdl/rtcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtcc_pkg;

  // One input request: a one-second tick or a full load of time and date.
  typedef struct packed {
    logic        kind;
    logic        load_hour_tens;
    logic [3:0]  load_hour_units;
    logic [2:0]  load_minute_tens;
    logic [3:0]  load_minute_units;
    logic [2:0]  load_second_tens;
    logic [3:0]  load_second_units;
    logic        load_pm;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
    logic [2:0]  load_weekday;
  } in_t;

  // One result: the time and date after the request.
  typedef struct packed {
    logic        hour_tens;
    logic [3:0]  hour_units;
    logic [2:0]  minute_tens;
    logic [3:0]  minute_units;
    logic [2:0]  second_tens;
    logic [3:0]  second_units;
    logic        is_pm;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [13:0] year;
  } out_t;

  // What every cell of the chain sees in a cycle.
  typedef struct packed {
    logic load;
    logic adv;
  } step_t;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned DIGIT_W    = 4;

  // Chain order: second units, second tens, minute units, minute tens.
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT [NUM_DIGITS] = '{4'd9, 4'd5, 4'd9, 4'd5};
  localparam logic [DIGIT_W-1:0] DIGIT_RST   [NUM_DIGITS] = '{4'd0, 4'd0, 4'd0, 4'd0};

  localparam logic       HOUR_TENS_RST  = 1'b1;
  localparam logic [3:0] HOUR_UNITS_RST = 4'd2;
  localparam logic       PM_RST         = 1'b0;
  localparam logic [4:0] DAY_RST        = 5'd1;
  localparam logic [3:0] MONTH_RST      = 4'd1;
  localparam logic [13:0] YEAR_RST      = 14'd2000;
  localparam logic [2:0] WEEKDAY_RST    = 3'd6;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [2:0]  WEEKDAY_MAX = 3'd6;

endpackage

`default_nettype wire

[hdl/rtcc_digit_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtcc_digit_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [rtcc_pkg::DIGIT_W-1:0] rst_val,
  input  wire logic [rtcc_pkg::DIGIT_W-1:0] limit,
  input  wire rtcc_pkg::step_t              step_i,
  input  wire logic [rtcc_pkg::DIGIT_W-1:0] load_val,
  output logic      [rtcc_pkg::DIGIT_W-1:0] digit_o,
  output logic      [rtcc_pkg::DIGIT_W-1:0] digit_nxt_o,
  output logic                              carry_o
);
  import rtcc_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic               at_limit;

  // A digit at or beyond its limit wraps to zero and passes the carry on.
  assign at_limit = (digit_r >= limit);
  assign carry_o  = step_i.adv && at_limit;

  always_comb begin
    digit_nxt = digit_r;
    if (step_i.load) begin
      digit_nxt = load_val;
    end else if (step_i.adv) begin
      digit_nxt = at_limit ? '0 : DIGIT_W'(digit_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= rst_val;
    end else begin
      digit_r <= digit_nxt;
    end
  end

  assign digit_o     = digit_r;
  assign digit_nxt_o = digit_nxt;

endmodule

`default_nettype wire

[hdl/rtcc_hour_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtcc_hour_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rtcc_pkg::step_t step_i,
  input  wire logic            load_tens,
  input  wire logic [3:0]      load_units,
  input  wire logic            load_pm,
  output logic                 tens_o,
  output logic      [3:0]      units_o,
  output logic                 pm_o,
  output logic                 tens_nxt_o,
  output logic      [3:0]      units_nxt_o,
  output logic                 pm_nxt_o,
  output logic                 day_carry_o
);
  import rtcc_pkg::*;

  logic       tens_r, tens_nxt;
  logic [3:0] units_r, units_nxt;
  logic       pm_r, pm_nxt;

  always_comb begin
    tens_nxt    = tens_r;
    units_nxt   = units_r;
    pm_nxt      = pm_r;
    day_carry_o = 1'b0;
    if (step_i.load) begin
      tens_nxt  = load_tens;
      units_nxt = load_units;
      pm_nxt    = load_pm;
    end else if (step_i.adv) begin
      if (tens_r) begin
        if (units_r == 4'd1) begin
          // Eleven to twelve: flip AM/PM, and midnight starts a new day.
          units_nxt   = 4'd2;
          pm_nxt      = !pm_r;
          day_carry_o = pm_r;
        end else if (units_r >= 4'd2) begin
          tens_nxt  = 1'b0;
          units_nxt = 4'd1;
        end else begin
          units_nxt = 4'(units_r + 4'd1);
        end
      end else begin
        if (units_r >= 4'd9) begin
          units_nxt = 4'd0;
          tens_nxt  = 1'b1;
        end else begin
          units_nxt = 4'(units_r + 4'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tens_r  <= HOUR_TENS_RST;
      units_r <= HOUR_UNITS_RST;
      pm_r    <= PM_RST;
    end else begin
      tens_r  <= tens_nxt;
      units_r <= units_nxt;
      pm_r    <= pm_nxt;
    end
  end

  assign tens_o      = tens_r;
  assign units_o     = units_r;
  assign pm_o        = pm_r;
  assign tens_nxt_o  = tens_nxt;
  assign units_nxt_o = units_nxt;
  assign pm_nxt_o    = pm_nxt;

endmodule

`default_nettype wire

[hdl/rtcc_date_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtcc_date_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rtcc_pkg::step_t step_i,
  input  wire logic [4:0]      load_day,
  input  wire logic [3:0]      load_month,
  input  wire logic [13:0]     load_year,
  input  wire logic [2:0]      load_weekday,
  output logic      [4:0]      day_nxt_o,
  output logic      [3:0]      month_nxt_o,
  output logic      [13:0]     year_nxt_o,
  output logic      [2:0]      weekday_nxt_o,
  output logic      [13:0]     year_o
);
  import rtcc_pkg::*;

  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic [2:0]  weekday_r, weekday_nxt;

  logic [26:0] quot_prod;
  logic [7:0]  cent;
  logic [14:0] cent_x100;
  logic        div100;
  logic        leap;
  logic [4:0]  month_len;

  // Year / 100 by reciprocal: 5243 / 2^19 is exact over the 14-bit range.
  assign quot_prod = 27'(year_r) * 27'd5243;
  assign cent      = quot_prod[26:19];
  assign cent_x100 = 15'({cent, 6'b0}) + 15'({cent, 5'b0}) + 15'({cent, 2'b0});
  assign div100    = (cent_x100 == {1'b0, year_r});
  // Leap when divisible by 4 and not by 100, or by 400.
  assign leap      = (year_r[1:0] == 2'b00) && (!div100 || (cent[1:0] == 2'b00));

  always_comb begin
    unique case (month_r)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = 5'd30;
      MONTH_FEB:                                  month_len = leap ? 5'd29 : 5'd28;
      default:                                    month_len = 5'd31;
    endcase
  end

  always_comb begin
    day_nxt     = day_r;
    month_nxt   = month_r;
    year_nxt    = year_r;
    weekday_nxt = weekday_r;
    if (step_i.load) begin
      day_nxt     = load_day;
      month_nxt   = load_month;
      year_nxt    = load_year;
      weekday_nxt = load_weekday;
    end else if (step_i.adv) begin
      if (day_r >= month_len) begin
        day_nxt = 5'd1;
        if (month_r >= MONTH_DEC) begin
          month_nxt = 4'd1;
          year_nxt  = (year_r >= YEAR_MAX) ? '0 : 14'(year_r + 14'd1);
        end else begin
          month_nxt = 4'(month_r + 4'd1);
        end
      end else begin
        day_nxt = 5'(day_r + 5'd1);
      end
      weekday_nxt = (weekday_r >= WEEKDAY_MAX) ? '0 : 3'(weekday_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r     <= DAY_RST;
      month_r   <= MONTH_RST;
      year_r    <= YEAR_RST;
      weekday_r <= WEEKDAY_RST;
    end else begin
      day_r     <= day_nxt;
      month_r   <= month_nxt;
      year_r    <= year_nxt;
      weekday_r <= weekday_nxt;
    end
  end

  assign day_nxt_o     = day_nxt;
  assign month_nxt_o   = month_nxt;
  assign year_nxt_o    = year_nxt;
  assign weekday_nxt_o = weekday_nxt;
  assign year_o        = year_r;

endmodule

`default_nettype wire

[hdl/bcd_clock_calendar_12h.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   rtcc_pkg::in_t  (tick or load request)
// out_      output     out_valid / out_ready rtcc_pkg::out_t (time and date after it)
//
// Every request produces exactly one result, registered in the cycle after acceptance.
// A request is taken whenever the result register is empty or draining: one per cycle.
// The whole tick carry, from the seconds digit through to the year, settles in the same cycle;
// the slowest path is the leap-year test, one constant multiply plus a compare.
// Synchronous active-low reset sets 12:00:00 AM, Saturday 1 January 2000 and empties the output.
// A stalled output holds its result; requests wait until it is taken.

module bcd_clock_calendar_12h (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rtcc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rtcc_pkg::out_t      out_data
);
  import rtcc_pkg::*;

  logic               accept;
  logic               is_load;
  logic               is_tick;

  // Carry chain through the four minute and second digit cells.
  logic [NUM_DIGITS:0]  carry;
  logic [DIGIT_W-1:0]   digit     [NUM_DIGITS];
  logic [DIGIT_W-1:0]   digit_nxt [NUM_DIGITS];
  logic [DIGIT_W-1:0]   load_val  [NUM_DIGITS];

  logic        hour_tens, hour_tens_nxt;
  logic [3:0]  hour_units, hour_units_nxt;
  logic        pm, pm_nxt;
  logic        day_carry;

  logic [4:0]  day_nxt;
  logic [3:0]  month_nxt;
  logic [13:0] year_nxt;
  logic [2:0]  weekday_nxt;
  logic [13:0] year_cur;

  out_t        out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // The result register decouples the two sides: a new request may enter while the
  // previous result is leaving in the same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_load  = accept && in_data.kind;
  assign is_tick  = accept && !in_data.kind;

  assign load_val[0] = in_data.load_second_units;
  assign load_val[1] = {1'b0, in_data.load_second_tens};
  assign load_val[2] = in_data.load_minute_units;
  assign load_val[3] = {1'b0, in_data.load_minute_tens};

  assign carry[0] = is_tick;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
    rtcc_digit_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .rst_val     (DIGIT_RST[i]),
      .limit       (DIGIT_LIMIT[i]),
      .step_i      ('{load: is_load, adv: carry[i]}),
      .load_val    (load_val[i]),
      .digit_o     (digit[i]),
      .digit_nxt_o (digit_nxt[i]),
      .carry_o     (carry[i+1])
    );
  end

  // The hour cell takes the carry out of the minute tens digit.
  rtcc_hour_cell u_hour (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      ('{load: is_load, adv: carry[NUM_DIGITS]}),
    .load_tens   (in_data.load_hour_tens),
    .load_units  (in_data.load_hour_units),
    .load_pm     (in_data.load_pm),
    .tens_o      (hour_tens),
    .units_o     (hour_units),
    .pm_o        (pm),
    .tens_nxt_o  (hour_tens_nxt),
    .units_nxt_o (hour_units_nxt),
    .pm_nxt_o    (pm_nxt),
    .day_carry_o (day_carry)
  );

  // The calendar cell advances on the midnight carry from the hour cell.
  rtcc_date_cell u_date (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        ('{load: is_load, adv: day_carry}),
    .load_day      (in_data.load_day),
    .load_month    (in_data.load_month),
    .load_year     (in_data.load_year),
    .load_weekday  (in_data.load_weekday),
    .day_nxt_o     (day_nxt),
    .month_nxt_o   (month_nxt),
    .year_nxt_o    (year_nxt),
    .weekday_nxt_o (weekday_nxt),
    .year_o        (year_cur)
  );

  // The result is the state as it stands after the request.
  always_comb begin
    out_nxt = out_r;
    if (accept) begin
      out_nxt.hour_tens    = hour_tens_nxt;
      out_nxt.hour_units   = hour_units_nxt;
      out_nxt.minute_tens  = digit_nxt[3][2:0];
      out_nxt.minute_units = digit_nxt[2];
      out_nxt.second_tens  = digit_nxt[1][2:0];
      out_nxt.second_units = digit_nxt[0];
      out_nxt.is_pm        = pm_nxt;
      out_nxt.weekday      = weekday_nxt;
      out_nxt.day_of_month = day_nxt;
      out_nxt.month        = month_nxt;
      out_nxt.year         = year_nxt;
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Every accepted request leaves a result in the register on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  // A load is reflected verbatim in the result: the seconds units digit and the year are checked.
  a_load_seconds: assert property (@(posedge clk) disable iff (!rst_n)
    is_load |=> (out_data.second_units == $past(in_data.load_second_units))
                && (out_data.year == $past(in_data.load_year)))
    else $error("loaded value not returned");

  // A tick without a seconds carry only steps the seconds units digit.
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && (digit[0] < DIGIT_LIMIT[0]))
      |=> (out_data.second_units == 4'($past(digit[0]) + 4'd1)))
    else $error("seconds units digit did not step");

  // The year moves on a tick only through the midnight carry.
  a_year_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && !day_carry) |=> $stable(year_cur))
    else $error("year changed without a day carry");

  // A waiting result always shows the time held in the cells.
  a_result_is_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hour_tens == hour_tens) && (out_data.hour_units == hour_units)
                  && (out_data.is_pm == pm)
                  && ({1'b0, out_data.minute_tens} == digit[3])
                  && (out_data.minute_units == digit[2])
                  && ({1'b0, out_data.second_tens} == digit[1])
                  && (out_data.second_units == digit[0])
                  && (out_data.year == year_cur))
    else $error("result register differs from the clock state");
`endif

endmodule

`default_nettype wire
